>>> rtl/core/kdir_pkg.sv
// Shared types, sizes and codes of the key directory.
package kdir_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_LOOKUP   = 2'd1;

   localparam logic KIND_ACK      = 1'b0;
   localparam logic KIND_RESPONSE = 1'b1;

   localparam logic [2:0] OUT_INSERTED  = 3'd0;
   localparam logic [2:0] OUT_UPDATED   = 3'd1;
   localparam logic [2:0] OUT_FULL      = 3'd2;
   localparam logic [2:0] OUT_FOUND     = 3'd3;
   localparam logic [2:0] OUT_NOT_FOUND = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } kdir_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } kdir_cmd_type;

   typedef struct packed {
      logic op_known;
      logic hit;
      logic exhausted;
      logic out_free;
   } kdir_status_type;

endpackage

>>> rtl/core/key_directory_upsert_lookup.sv
// Top level of the key directory: sequencer plus datapath.
//
// Directory of up to TABLE_ENTRIES identifier/key pairs held in two RAMs. A register
// beat updates a matching entry or appends a new one (dropped when full); a lookup
// beat returns the stored key or 0. Operations 2 and 3 are taken and give no reply,
// in the accept cycle alone. Otherwise one request is handled at a time: an accept
// state, a scan over the filled entries that ends early on a hit, and a commit
// state. The linear scan reads one entry per cycle through the single read port of
// the identifier RAM. The commit waits while an earlier reply is still held; the
// reply sits in an output register, so the next request is taken while it waits.
module key_directory_upsert_lookup
   import kdir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_user_id,
   input  logic [31:0] req_public_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_kind,
   output logic [31:0] rsp_user_id_echo,
   output logic [31:0] rsp_key_out,
   output logic [2:0]  rsp_outcome
);

   kdir_cmd_type    cmd;
   kdir_status_type status;

   kdir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kdir_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_user_id      (req_user_id),
      .req_public_key   (req_public_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_user_id_echo (rsp_user_id_echo),
      .rsp_key_out      (rsp_key_out),
      .rsp_outcome      (rsp_outcome)
   );

endmodule

>>> rtl/core/kdir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kdir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/kdir_ctrl.sv
// Sequencer of the key directory: accept, scan, commit.
module kdir_ctrl
   import kdir_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  kdir_status_type status,
   output kdir_cmd_type    cmd
);

   kdir_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // drop unknown operations on acceptance
            if (req_valid && status.op_known) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.exhausted) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/core/kdir_dp.sv
// Datapath of the key directory: request latch, tables, scan and result register.
module kdir_dp
   import kdir_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  kdir_cmd_type    cmd,
   output kdir_status_type status,
   input  logic [1:0]      req_operation,
   input  logic [31:0]     req_user_id,
   input  logic [31:0]     req_public_key,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_reply_kind,
   output logic [31:0]     rsp_user_id_echo,
   output logic [31:0]     rsp_key_out,
   output logic [2:0]      rsp_outcome
);

   logic [1:0]       op_ff;
   logic [31:0]      uid_ff;
   logic [31:0]      key_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] slot_ff;
   logic [31:0]      hkey_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             kind_ff;
   logic [31:0]      echo_ff;
   logic [31:0]      kout_ff;
   logic [2:0]       outc_ff;

   logic             rd_en;
   logic [31:0]      rd_id;
   logic [31:0]      rd_key;
   logic             more;
   logic             match;
   logic             full;

   logic             id_we;
   logic             key_we;
   logic [IDX_W-1:0] key_waddr;

   assign more  = (iss_ff < fill_ff);
   assign match = pend_ff && (rd_id == uid_ff);
   assign full  = (fill_ff == CNT_W'(TABLE_ENTRIES));
   assign rd_en = cmd.scan && more;

   assign status.op_known  = (req_operation == OP_REGISTER) || (req_operation == OP_LOOKUP);
   assign status.hit       = match;
   assign status.exhausted = !pend_ff && !more;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // table writes happen only at commit of a register beat
   always_comb begin
      id_we     = 1'b0;
      key_we    = 1'b0;
      key_waddr = fill_ff[IDX_W-1:0];
      if (cmd.commit && (op_ff == OP_REGISTER)) begin
         priority if (hit_ff) begin
            key_we    = 1'b1;
            key_waddr = slot_ff;
         end else if (!full) begin
            id_we  = 1'b1;
            key_we = 1'b1;
         end else begin
            // table full: drop the pair
            id_we = 1'b0;
         end
      end
   end

   kdir_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (uid_ff),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_id)
   );

   kdir_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_key)
   );

   always_comb begin
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (cmd.load) begin
         iss_in  = '0;
         pend_in = 1'b0;
         hit_in  = 1'b0;
      end else if (cmd.scan) begin
         // issue the next entry while comparing the one read last cycle
         pend_in = more;
         if (more) begin
            iss_in = iss_ff + CNT_W'(1);
         end
         if (match) begin
            hit_in = 1'b1;
         end
      end else if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (id_we) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end else begin
         // hold the scan state between requests
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         uid_ff <= req_user_id;
         key_ff <= req_public_key;
      end
      if (rd_en) begin
         pidx_ff <= iss_ff[IDX_W-1:0];
      end
      if (cmd.scan && match && !hit_ff) begin
         slot_ff <= pidx_ff;
         hkey_ff <= rd_key;
      end
      if (cmd.commit) begin
         echo_ff <= uid_ff;
         if (op_ff == OP_REGISTER) begin
            kind_ff <= KIND_ACK;
            kout_ff <= key_ff;
            priority if (hit_ff) begin
               outc_ff <= OUT_UPDATED;
            end else if (!full) begin
               outc_ff <= OUT_INSERTED;
            end else begin
               outc_ff <= OUT_FULL;
            end
         end else begin
            kind_ff <= KIND_RESPONSE;
            kout_ff <= hit_ff ? hkey_ff : 32'd0;
            outc_ff <= hit_ff ? OUT_FOUND : OUT_NOT_FOUND;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = kind_ff;
   assign rsp_user_id_echo = echo_ff;
   assign rsp_key_out      = kout_ff;
   assign rsp_outcome      = outc_ff;

endmodule

>>> test/testbench.sv
// Testbench of the key directory: directed and random requests checked against a scoreboard.
`timescale 1ns / 100ps

module testbench
   import kdir_pkg::*;
();

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 600;
   localparam int ID_POOL_SIZE   = 48;
   localparam int CALM_TAIL      = 80;
   localparam int HOLD_AFTER     = 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 2 * TABLE_ENTRIES + 8;
   localparam int MAX_REPORTS    = 10;

   // operation codes the block takes and ignores
   localparam logic [1:0] OP_SPARE_LO = 2'd2;
   localparam logic [1:0] OP_SPARE_HI = 2'd3;

   localparam logic [31:0] ALL_ZERO = 32'h0000_0000;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] user_id;
      logic [31:0] public_key;
   } dir_request_type;

   typedef struct packed {
      logic        reply_kind;
      logic [31:0] user_id_echo;
      logic [31:0] key_out;
      logic [2:0]  outcome;
   } dir_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_LOOKUP;
   logic [31:0] req_user_id = ALL_ZERO;
   logic [31:0] req_public_key = ALL_ZERO;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_reply_kind;
   logic [31:0] rsp_user_id_echo;
   logic [31:0] rsp_key_out;
   logic [2:0]  rsp_outcome;

   // directory as the scoreboard sees it
   logic [31:0] dir_ids [TABLE_ENTRIES];
   logic [31:0] dir_keys [TABLE_ENTRIES];
   int          dir_fill = 0;

   dir_request_type pending_requests[$];
   dir_reply_type   expected_replies[$];
   logic [31:0]     id_pool [ID_POOL_SIZE];

   int requests_taken = 0;
   int total_requests = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   key_directory_upsert_lookup i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_user_id      (req_user_id),
      .req_public_key   (req_public_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_user_id_echo (rsp_user_id_echo),
      .rsp_key_out      (rsp_key_out),
      .rsp_outcome      (rsp_outcome)
   );

   always #HALF_PERIOD clock = ~clock;

   // Apply one request to the directory copy; returns 1 when it earns a reply.
   function automatic bit predict_directory(input dir_request_type item,
                                            output dir_reply_type reply);
      int slot;
      bit hit;
      bit gives_reply;
      slot = 0;
      hit = 0;
      gives_reply = 1;
      for (int i = 0; i < dir_fill; i++) begin
         if (!hit && dir_ids[i] == item.user_id) begin
            hit = 1;
            slot = i;
         end
      end
      reply = '0;
      reply.user_id_echo = item.user_id;
      case (item.operation)
         OP_REGISTER: begin
            reply.reply_kind = KIND_ACK;
            reply.key_out = item.public_key;
            if (hit) begin
               dir_keys[slot] = item.public_key;
               reply.outcome = OUT_UPDATED;
            end else if (dir_fill < TABLE_ENTRIES) begin
               dir_ids[dir_fill] = item.user_id;
               dir_keys[dir_fill] = item.public_key;
               dir_fill++;
               reply.outcome = OUT_INSERTED;
            end else begin
               reply.outcome = OUT_FULL;
            end
         end
         OP_LOOKUP: begin
            reply.reply_kind = KIND_RESPONSE;
            reply.key_out = hit ? dir_keys[slot] : ALL_ZERO;
            reply.outcome = hit ? OUT_FOUND : OUT_NOT_FOUND;
         end
         default: gives_reply = 0;
      endcase
      return gives_reply;
   endfunction

   function automatic void note_mismatch(input string what, input dir_reply_type want,
                                         input dir_reply_type got);
      if (mismatch_count < MAX_REPORTS)
         $display({"%0t %s: expected kind %0d id %h key %h outcome %0d, ",
                   "got kind %0d id %h key %h outcome %0d"},
                  $realtime, what, want.reply_kind, want.user_id_echo, want.key_out, want.outcome,
                  got.reply_kind, got.user_id_echo, got.key_out, got.outcome);
      mismatch_count++;
   endfunction

   function automatic void push_request(input logic [1:0] op, input logic [31:0] uid,
                                        input logic [31:0] key);
      dir_request_type item;
      item.operation = op;
      item.user_id = uid;
      item.public_key = key;
      pending_requests.push_back(item);
   endfunction

   function automatic logic [31:0] random_key();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return ALL_ZERO;
      if (pick == 1)
         return ALL_ONES;
      return $urandom;
   endfunction

   // Identifiers come mostly from a pool that widens as the run goes on, so the
   // table fills gradually and updates and hits stay common.
   function automatic dir_request_type random_request(input int index);
      dir_request_type item;
      int pick;
      int pool_top;
      pick = $urandom_range(0, 19);
      if (pick < 9)
         item.operation = OP_REGISTER;
      else if (pick < 18)
         item.operation = OP_LOOKUP;
      else
         item.operation = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      pool_top = 4 + index / 6;
      if (pool_top > ID_POOL_SIZE - 1)
         pool_top = ID_POOL_SIZE - 1;
      if ($urandom_range(0, 9) == 0)
         item.user_id = $urandom;
      else
         item.user_id = id_pool[$urandom_range(0, pool_top)];
      item.public_key = random_key();
      return item;
   endfunction

   // Request driver: change inputs at the falling edge.
   always @(negedge clock) begin : drive_requests
      dir_request_type next_item;
      logic            drive_valid;
      int              gap_left;
      int              taken_seen;
      bit              gaps_on;
      next_item = {req_operation, req_user_id, req_public_key};
      // a beat taken at the last rising edge shows as a new count
      drive_valid = req_valid && (requests_taken == taken_seen);
      taken_seen = requests_taken;
      gaps_on = (requests_taken < total_requests - CALM_TAIL) && ((requests_taken / 64) % 4 != 3);
      if (reset) begin
         drive_valid = 1'b0;
      end else if (!drive_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 10) - 1;
         end else if (pending_requests.size() > 0) begin
            next_item = pending_requests.pop_front();
            drive_valid = 1'b1;
         end
      end
      req_valid <= drive_valid;
      {req_operation, req_user_id, req_public_key} <= next_item;
   end

   // Reply receiver: random stalls plus one long hold-off to back the block up.
   always @(negedge clock) begin : drive_ready
      logic ready_next;
      int   stall_left;
      int   hold_left;
      bit   hold_done;
      bit   gaps_on;
      ready_next = 1'b1;
      gaps_on = (requests_taken < total_requests - CALM_TAIL) && ((requests_taken / 64) % 4 != 2);
      if (!hold_done && requests_taken >= HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         ready_next = 1'b0;
      end
      rsp_ready <= ready_next;
   end

   // Check replies before predicting, so a reply never meets its own request's entry.
   always @(posedge clock) begin : check_and_predict
      dir_reply_type seen;
      dir_reply_type want;
      dir_reply_type predicted;
      bit            any_beat;
      any_beat = 0;
      if (!reset && rsp_valid && rsp_ready) begin
         any_beat = 1;
         seen = {rsp_reply_kind, rsp_user_id_echo, rsp_key_out, rsp_outcome};
         if (expected_replies.size() == 0) begin
            note_mismatch("reply with nothing outstanding", '0, seen);
         end else begin
            want = expected_replies.pop_front();
            if (seen.reply_kind !== want.reply_kind || seen.user_id_echo !== want.user_id_echo ||
                seen.key_out !== want.key_out || seen.outcome !== want.outcome)
               note_mismatch("reply mismatch", want, seen);
         end
      end
      if (!reset && req_valid && req_ready) begin
         any_beat = 1;
         requests_taken++;
         if (predict_directory({req_operation, req_user_id, req_public_key}, predicted))
            expected_replies.push_back(predicted);
      end
      quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles, %0d replies outstanding",
                  $realtime, WATCHDOG_LIMIT, expected_replies.size());
         $display("** key_directory_upsert_lookup: FAILED **");
         $finish;
      end
   end

   initial begin : run_stimulus
      int known_ops;
      int index;
      dir_request_type item;

      id_pool[0] = ALL_ZERO;
      id_pool[1] = ALL_ONES;
      for (int i = 2; i < ID_POOL_SIZE; i++)
         id_pool[i] = $urandom;

      // directed: empty table, extremes, update, ignored operations
      push_request(OP_LOOKUP,   ALL_ZERO,     ALL_ONES);
      push_request(OP_REGISTER, ALL_ZERO,     ALL_ZERO);
      push_request(OP_REGISTER, ALL_ONES,     ALL_ONES);
      push_request(OP_LOOKUP,   ALL_ZERO,     ALL_ZERO);
      push_request(OP_LOOKUP,   ALL_ONES,     ALL_ZERO);
      push_request(OP_REGISTER, ALL_ZERO,     ALL_ONES);
      push_request(OP_LOOKUP,   ALL_ZERO,     ALL_ZERO);
      push_request(OP_SPARE_LO, ALL_ONES,     ALL_ONES);
      push_request(OP_SPARE_HI, ALL_ZERO,     ALL_ZERO);
      push_request(OP_LOOKUP,   32'hA5A5A5A5, ALL_ONES);
      push_request(OP_REGISTER, 32'h5A5A5A5A, 32'h12345678);
      push_request(OP_REGISTER, ALL_ONES,     ALL_ZERO);
      push_request(OP_LOOKUP,   ALL_ONES,     ALL_ONES);
      push_request(OP_SPARE_HI, 32'h5A5A5A5A, 32'hDEADBEEF);
      push_request(OP_SPARE_LO, ALL_ZERO,     ALL_ONES);
      push_request(OP_LOOKUP,   32'h5A5A5A5A, ALL_ZERO);
      push_request(OP_REGISTER, 32'hA5A5A5A5, ALL_ONES);
      push_request(OP_LOOKUP,   32'hA5A5A5A5, ALL_ZERO);

      // random: count only operations that the block acts on
      known_ops = 0;
      index = 0;
      while (known_ops < RANDOM_ITEMS) begin
         item = random_request(index);
         pending_requests.push_back(item);
         if (item.operation == OP_REGISTER || item.operation == OP_LOOKUP)
            known_ops++;
         index++;
      end
      total_requests = pending_requests.size();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0)
         $display("** key_directory_upsert_lookup: PASSED **");
      else
         $display("** key_directory_upsert_lookup: FAILED **");
      $finish;
   end

endmodule
